// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/crlf_pkg.sv
`default_nettype none
package crlf_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam int CRLF_BYTES = 2;
  localparam logic [LEN_W-1:0] LINE_CAP     = 6'd61;
  localparam logic [LEN_W-1:0] LEN_RESET    = 6'd31;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              last;
    logic [LEN_W-1:0]  line_length;
    logic              truncated;
  } out_word_t;

endpackage
`default_nettype wire

// File: rtl/crlf_line_deframer_ring.sv
// Channel  | Handshake                 | Word
// in       | in_valid / in_stall       | in_data  (op, data_byte)
// out      | out_valid / out_stall     | out_data (line_byte, last, line_length, truncated)
// cfg      | cfg_valid / cfg_ready     | cfg_data (max_line_len)
//
// A push that stores CR LF moves to a state that sizes the line, then emits each
// byte through a ring RAM read state and a state that loads the output
// register. in_stall is high for that whole line.
// Synchronous active-high reset empties the ring and sets max_line_len to 31;
// no clearing pass. out_stall holds the output word and pauses the next read.
`default_nettype none
`include "assert_macros.svh"
module crlf_line_deframer_ring
  import crlf_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int PND_W = PTR_W + 1;
  localparam int CMP_W = (PND_W > LEN_W) ? PND_W : LEN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LD   = 2'd3;

  logic [1:0]        state;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  rd_addr;
  logic              cr_seen;
  logic [LEN_W-1:0]  max_line_len;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  n;
  logic              trunc;

  logic              in_acc;
  logic              is_push;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic              full;
  logic              do_write;
  logic              line_done;
  logic [PND_W-1:0]  pend;
  logic [PND_W-1:0]  count;
  logic [LEN_W-1:0]  limit;
  logic              over;
  logic [LEN_W-1:0]  n_next;
  logic              out_free;
  logic [BYTE_W-1:0] rd_data;
  logic              is_last;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_push   = (in_data.op == OP_PUSH);

  assign wr_ptr_next = ptr_inc(wr_ptr);
  assign full        = (wr_ptr_next == rd_ptr);
  assign do_write    = in_acc && is_push && !full;
  assign line_done   = (in_data.data_byte == CHAR_LF) && cr_seen;

  // pending bytes, modulo the ring depth
  assign pend  = {1'b0, wr_ptr} - {1'b0, rd_ptr}
               + ((wr_ptr < rd_ptr) ? PND_W'(RING_DEPTH) : '0);
  assign count = (pend >= PND_W'(CRLF_BYTES)) ? pend - PND_W'(CRLF_BYTES) : '0;

  assign limit = (max_line_len == '0)      ? LEN_W'(1) :
                 (max_line_len > LINE_CAP) ? LINE_CAP  : max_line_len;
  assign over   = CMP_W'(count) > CMP_W'(limit);
  assign n_next = over ? limit : LEN_W'(count);

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (idx + 1'b1) == n;

  crlf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (wr_ptr),
    .wr_data (in_data.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_line_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      cr_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && !is_push) begin
            rd_ptr  <= wr_ptr;
            cr_seen <= 1'b0;
          end else if (do_write) begin
            wr_ptr <= wr_ptr_next;
            if (line_done) begin
              cr_seen <= 1'b0;
              state   <= ST_CALC;
            end else begin
              cr_seen <= (in_data.data_byte == CHAR_CR);
            end
          end
        end
        ST_CALC: begin
          if (n_next == '0) begin
            // empty line: just drop the CR LF
            rd_ptr <= wr_ptr;
            state  <= ST_IDLE;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (out_free) begin
            state <= ST_LD;
          end
        end
        ST_LD: begin
          if (is_last) begin
            // rest of a truncated line goes with the CR LF
            rd_ptr <= wr_ptr;
            state  <= ST_IDLE;
          end else begin
            state <= ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CALC: begin
        n       <= n_next;
        trunc   <= over;
        idx     <= '0;
        rd_addr <= rd_ptr;
      end
      ST_LD: begin
        idx     <= idx + 1'b1;
        rd_addr <= ptr_inc(rd_addr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LD) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LD) begin
      out_data.line_byte   <= rd_data;
      out_data.last        <= is_last;
      out_data.line_length <= n;
      out_data.truncated   <= trunc;
    end
  end

  `ASSERT_CLK(a_ld_slot_free, clk, rst, (state == ST_LD) |-> !out_valid, "output word overwritten")
  `ASSERT_CLK(a_rd_in_range, clk, rst, (state == ST_RD) |-> (idx < n), "read beyond line length")
  `ASSERT_CLK(a_clear_empties, clk, rst, (in_acc && in_data.op == OP_CLEAR) |=> (rd_ptr == wr_ptr && !cr_seen), "clear left bytes pending")
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !out_valid && rd_ptr == wr_ptr), "reset did not empty the block")

endmodule
`default_nettype wire

// File: rtl/crlf_ram.sv
`default_nettype none
module crlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
